// ----- hw/rtl/mbrs_pkg.sv -----
// ============================================================================
// Modbus RTU slave register bank - shared package
// Types, function codes and the CRC-16 byte step used by the controller and
// the datapath.
// ============================================================================
`default_nettype none

package mbrs_pkg;

  // Input word selector, carried in tuser.
  localparam logic [1:0] CMD_BUS   = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Modbus function codes served.
  localparam logic [7:0] FC_READ_COILS    = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
  localparam logic [7:0] FC_READ_INPUT    = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
  localparam logic [7:0] FC_WRITE_REG     = 8'd6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] COIL_ON  = 16'hFF00;
  localparam logic [15:0] INPUT_EXTRA = 16'd5;
  localparam logic [2:0]  FRAME_LAST = 3'd7;

  // Source of the byte loaded into the output register.
  typedef enum logic [2:0] {
    SEL_HDR   = 3'd0,
    SEL_BITS  = 3'd1,
    SEL_WHI   = 3'd2,
    SEL_WLO   = 3'd3,
    SEL_CRCLO = 3'd4,
    SEL_CRCHI = 3'd5,
    SEL_LOCAL = 3'd6
  } push_sel_e;

  typedef struct packed {
    logic      take_bus;
    logic      loc_wr;
    logic      loc_rd;
    logic      clr_wr;
    logic      bank_wr;
    logic      bus_rd;
    logic      reply_init;
    logic      hdr_inc;
    logic      acc_bit;
    logic      k_inc;
    logic      push;
    logic      last;
    push_sel_e sel;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic frame_good;
    logic out_free;
    logic is_write;
    logic is_bits;
    logic reply_ok;
    logic hdr_last;
    logic byte_end;
    logic k_last;
    logic k_end;
  } dp_stat_t;

  // One byte of CRC-16 (reflected), eight shift steps.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mbrs_ram.sv -----
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module mbrs_ram #(
  parameter int Width = 16,
  parameter int Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mbrs_datapath.sv -----
// ============================================================================
// Modbus RTU slave datapath
// Frame capture and CRC check, register bank, reply assembly and the output
// register.
// ============================================================================
`default_nettype none

module mbrs_datapath import mbrs_pkg::*; #(
  parameter int Groups   = 4,
  parameter int PerGroup = 32,
  parameter int RespMax  = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic [39:0] in_data_i,
  input  wire logic [1:0]  in_cmd_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic [23:0]      out_data_o,
  output logic             out_kind_o,
  output logic             out_last_o,
  input  wire dp_cmd_t     cmd_i,
  output dp_stat_t         stat_o
);

  localparam int N  = Groups * PerGroup;
  localparam int AW = $clog2(N);

  logic [7:0]  slave_id_q;
  logic [2:0]  rx_phase_q, rx_phase_d;
  logic [15:0] rx_crc_q, rx_crc_d;
  logic [7:0]  frame_q [8];
  logic [AW-1:0] clr_q;
  logic [15:0] k_q;
  logic [7:0]  acc_q;
  logic [2:0]  hdr_q;
  logic [15:0] tx_crc_q;
  logic        rd_ok_q;
  logic        out_valid_q;
  logic        out_kind_q, out_last_q;
  logic [7:0]  out_byte_q;
  logic [15:0] out_rv_q;

  logic [7:0]  rx_byte, lg, la, fc;
  logic [15:0] lv, w2, w4, cnt16, idx16, rd_raw, rd_data, bus_wdata;
  logic        loc_ok, bus_ok, is_bits, is_words, is_write;
  logic [17:0] bc_bits, total;
  logic [7:0]  bc_byte, hdr_byte, push_byte;
  logic [1:0]  bus_grp;
  logic [AW-1:0] loc_addr, bus_addr, raddr, waddr;
  logic        we, re;
  logic [15:0] wdata;

  assign rx_byte = in_data_i[7:0];
  assign lg      = in_data_i[15:8];
  assign la      = in_data_i[23:16];
  assign lv      = in_data_i[39:24];

  assign loc_ok   = (32'(lg) < 32'(Groups)) && (32'(la) < 32'(PerGroup));
  assign loc_addr = AW'(32'(lg) * 32'(PerGroup) + 32'(la));

  assign fc = frame_q[1];
  assign w2 = {frame_q[2], frame_q[3]};
  assign w4 = {frame_q[4], frame_q[5]};

  assign is_bits  = (fc == FC_READ_COILS) || (fc == FC_READ_DISCRETE);
  assign is_words = (fc == FC_READ_HOLDING) || (fc == FC_READ_INPUT);
  assign is_write = (fc == FC_WRITE_COIL) || (fc == FC_WRITE_REG);

  assign cnt16   = (fc == FC_READ_INPUT) ? w4 + INPUT_EXTRA : w4;
  assign bc_bits = ({2'b00, cnt16} + 18'd7) >> 3;
  assign total   = is_bits ? bc_bits + 18'd5 : {1'b0, cnt16, 1'b0} + 18'd5;
  assign bc_byte = is_bits ? bc_bits[7:0] : {cnt16[6:0], 1'b0};

  // Bank group of a bus access: reads use code minus one, writes 0 or 2.
  always_comb begin
    if (is_write) begin
      bus_grp = (fc == FC_WRITE_REG) ? 2'd2 : 2'd0;
    end else begin
      bus_grp = fc[1:0] - 2'd1;
    end
  end

  assign idx16     = is_write ? w2 : w2 + k_q;
  assign bus_ok    = 32'(idx16) < 32'(PerGroup);
  assign bus_addr  = AW'(32'(bus_grp) * 32'(PerGroup) + 32'(idx16));
  assign bus_wdata = (fc == FC_WRITE_COIL) ? {15'd0, w4 == COIL_ON} : w4;

  // Bank ports.
  assign re    = cmd_i.loc_rd | cmd_i.bus_rd;
  assign raddr = cmd_i.loc_rd ? loc_addr : bus_addr;
  always_comb begin
    we    = 1'b0;
    waddr = clr_q;
    wdata = '0;
    if (cmd_i.clr_wr) begin
      we = 1'b1;
    end else if (cmd_i.loc_wr) begin
      we    = loc_ok;
      waddr = loc_addr;
      wdata = lv;
    end else if (cmd_i.bank_wr) begin
      we    = bus_ok;
      waddr = bus_addr;
      wdata = bus_wdata;
    end
  end

  mbrs_ram #(.Width(16), .Depth(N)) u_bank (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_raw)
  );

  assign rd_data = rd_ok_q ? rd_raw : 16'd0;

  // Frame reception.
  always_comb begin
    rx_phase_d = rx_phase_q;
    rx_crc_d   = rx_crc_q;
    if (rx_phase_q == 3'd0) begin
      if (rx_byte == slave_id_q) begin
        rx_phase_d = 3'd1;
        rx_crc_d   = crc16_byte(CRC_INIT, rx_byte);
      end
    end else begin
      rx_phase_d = rx_phase_q + 3'd1;
      if (rx_phase_q < 3'd6) begin
        rx_crc_d = crc16_byte(rx_crc_q, rx_byte);
      end
    end
  end

  always_comb begin
    hdr_byte = frame_q[hdr_q];
    if (!is_write && hdr_q == 3'd2) begin
      hdr_byte = bc_byte;
    end
  end

  always_comb begin
    case (cmd_i.sel)
      SEL_HDR:   push_byte = hdr_byte;
      SEL_BITS:  push_byte = acc_q;
      SEL_WHI:   push_byte = rd_data[15:8];
      SEL_WLO:   push_byte = rd_data[7:0];
      SEL_CRCLO: push_byte = tx_crc_q[7:0];
      SEL_CRCHI: push_byte = tx_crc_q[15:8];
      default:   push_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_id_q  <= 8'd1;
      rx_phase_q  <= 3'd0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        slave_id_q <= cfg_data_i;
      end
      if (cmd_i.take_bus) begin
        rx_phase_q <= rx_phase_d;
      end
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_bus) begin
      rx_crc_q <= rx_crc_d;
      frame_q[rx_phase_q] <= rx_byte;
    end
    if (cmd_i.loc_rd) begin
      rd_ok_q <= loc_ok;
    end else if (cmd_i.bus_rd) begin
      rd_ok_q <= bus_ok;
    end
    if (cmd_i.reply_init) begin
      tx_crc_q <= CRC_INIT;
      hdr_q    <= 3'd0;
      k_q      <= 16'd0;
      acc_q    <= 8'd0;
    end else begin
      if (cmd_i.hdr_inc) begin
        hdr_q <= hdr_q + 3'd1;
      end
      if (cmd_i.k_inc) begin
        k_q <= k_q + 16'd1;
      end
      if (cmd_i.acc_bit) begin
        acc_q <= acc_q | (8'(rd_data[0]) << k_q[2:0]);
      end else if (cmd_i.push && cmd_i.sel == SEL_BITS) begin
        acc_q <= 8'd0;
      end
      if (cmd_i.push && (cmd_i.sel == SEL_HDR || cmd_i.sel == SEL_BITS ||
                         cmd_i.sel == SEL_WHI || cmd_i.sel == SEL_WLO)) begin
        tx_crc_q <= crc16_byte(tx_crc_q, push_byte);
      end
    end
    if (cmd_i.push) begin
      out_kind_q <= (cmd_i.sel == SEL_LOCAL);
      out_last_q <= cmd_i.last;
      out_byte_q <= push_byte;
      out_rv_q   <= (cmd_i.sel == SEL_LOCAL) ? rd_data : 16'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_rv_q, out_byte_q};
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    stat_o.clr_last   = (clr_q == AW'(N - 1));
    stat_o.frame_good = (in_cmd_i == CMD_BUS) && (rx_phase_q == FRAME_LAST) &&
                        (frame_q[6] == rx_crc_q[7:0]) && (rx_byte == rx_crc_q[15:8]);
    stat_o.out_free   = !out_valid_q || out_ready_i;
    stat_o.is_write   = is_write;
    stat_o.is_bits    = is_bits;
    stat_o.reply_ok   = (is_bits || is_words) && (cnt16 != 16'd0) &&
                        (total <= 18'(RespMax));
    stat_o.hdr_last   = is_write ? (hdr_q == 3'd5) : (hdr_q == 3'd2);
    stat_o.k_last     = (k_q + 16'd1) == cnt16;
    stat_o.k_end      = (k_q == cnt16);
    stat_o.byte_end   = (k_q[2:0] == 3'd7) || ((k_q + 16'd1) == cnt16);
  end

`ifndef SYNTH
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> stat_o.out_free) else $error("byte pushed into a full output");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.clr_wr, cmd_i.loc_wr, cmd_i.bank_wr})) else $error("bank write clash");
  a_one_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.loc_rd && cmd_i.bus_rd)) else $error("bank read clash");
  a_rx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.take_bus |=> $stable(rx_phase_q)) else $error("frame phase moved without a byte");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/mbrs_ctrl.sv -----
// ============================================================================
// Modbus RTU slave controller
// Sequences bank clearing, input words, local reads and reply bytes.
// ============================================================================
`default_nettype none

module mbrs_ctrl import mbrs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] in_cmd_i,
  output logic            in_ready_o,
  input  wire dp_stat_t   stat_i,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_LREAD = 13'b0000000000100,
    S_SERVE = 13'b0000000001000,
    S_HDR   = 13'b0000000010000,
    S_BRD   = 13'b0000000100000,
    S_BWT   = 13'b0000001000000,
    S_BPUSH = 13'b0000010000000,
    S_WRD   = 13'b0000100000000,
    S_WHI   = 13'b0001000000000,
    S_WLO   = 13'b0010000000000,
    S_CRCLO = 13'b0100000000000,
    S_CRCHI = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.sel  = SEL_HDR;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_cmd_i)
            CMD_BUS: begin
              cmd_o.take_bus = 1'b1;
              if (stat_i.frame_good) begin
                state_d = S_SERVE;
              end
            end
            CMD_WRITE: cmd_o.loc_wr = 1'b1;
            CMD_READ: begin
              cmd_o.loc_rd = 1'b1;
              state_d = S_LREAD;
            end
            default: ;
          endcase
        end
      end
      S_LREAD: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.last = 1'b1;
          cmd_o.sel  = SEL_LOCAL;
          state_d    = S_IDLE;
        end
      end
      S_SERVE: begin
        cmd_o.reply_init = 1'b1;
        cmd_o.bank_wr    = stat_i.is_write;
        if (stat_i.is_write || stat_i.reply_ok) begin
          state_d = S_HDR;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_HDR: begin
        if (stat_i.out_free) begin
          cmd_o.push    = 1'b1;
          cmd_o.hdr_inc = 1'b1;
          if (stat_i.hdr_last) begin
            if (stat_i.is_write) begin
              state_d = S_CRCLO;
            end else if (stat_i.is_bits) begin
              state_d = S_BRD;
            end else begin
              state_d = S_WRD;
            end
          end
        end
      end
      S_BRD: begin
        cmd_o.bus_rd = 1'b1;
        state_d = S_BWT;
      end
      S_BWT: begin
        cmd_o.acc_bit = 1'b1;
        cmd_o.k_inc   = 1'b1;
        state_d = stat_i.byte_end ? S_BPUSH : S_BRD;
      end
      S_BPUSH: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.sel  = SEL_BITS;
          state_d = stat_i.k_end ? S_CRCLO : S_BRD;
        end
      end
      S_WRD: begin
        cmd_o.bus_rd = 1'b1;
        state_d = S_WHI;
      end
      S_WHI: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.sel  = SEL_WHI;
          state_d = S_WLO;
        end
      end
      S_WLO: begin
        if (stat_i.out_free) begin
          cmd_o.push  = 1'b1;
          cmd_o.sel   = SEL_WLO;
          cmd_o.k_inc = 1'b1;
          state_d = stat_i.k_last ? S_CRCLO : S_WRD;
        end
      end
      S_CRCLO: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.sel  = SEL_CRCLO;
          state_d = S_CRCHI;
        end
      end
      S_CRCHI: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.last = 1'b1;
          cmd_o.sel  = SEL_CRCHI;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/modbus_rtu_slave_register_bank.sv -----
// ============================================================================
// Modbus RTU slave register bank - top level
// Register bank with a Modbus RTU frame server and local read/write access.
// ============================================================================
//
//   Channel   Direction  Handshake                    Contents
//   s_axis    in         s_axis_tvalid/s_axis_tready  command, bus byte, local access
//   m_axis    out        m_axis_tvalid/m_axis_tready  reply byte or local read word
//   cfg       in         cfg_valid_i/cfg_ready_o      own slave id
//
// After reset the bank is cleared word by word, during which no input word
// is taken. A bus byte or a local write is taken while the block is idle.
// A local read does a bank read and then waits for the output register.
// A served frame occupies the block for the length of its reply: a start
// step, each header and CRC byte, a bank read, high byte and low byte per
// read word, and a bank read and a gathering step per bit read plus a push
// per data byte of a bit read, plus stalls while the output register is full.
// A result waiting in the output register does not stop new input words.
//
`default_nettype none

module modbus_rtu_slave_register_bank import mbrs_pkg::*; #(
  parameter int GROUPS    = 4,
  parameter int PER_GROUP = 32,
  parameter int RESP_MAX  = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Own slave id.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i,
  // Input words.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // rx_byte[7:0], group[15:8], address[23:16],
                                          // value[39:24]
  input  wire logic [1:0]  s_axis_tuser,  // command[1:0]
  // Result words.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // tx_byte[7:0], read_value[23:8]
  output logic             m_axis_tuser,  // kind[0]
  output logic             m_axis_tlast   // last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The id register can always be written; software is to write it only while idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  mbrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mbrs_datapath #(
    .Groups   (GROUPS),
    .PerGroup (PER_GROUP),
    .RespMax  (RESP_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_cmd_i    (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

`default_nettype wire

// ----- bench/modbus_rtu_slave_register_bank_tb.sv -----
// ============================================================================
// Modbus RTU slave register bank - testbench
// Drives bus bytes and local bank accesses into the block, predicts every
// reply byte and local read answer with a model of the slave kept inside the
// bench, and compares each result word field by field as it leaves the block.
// ============================================================================

module modbus_rtu_slave_register_bank_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbrs_pkg::*;

  localparam int GROUPS    = 4;
  localparam int PER_GROUP = 32;
  localparam int RESP_MAX  = 64;
  localparam int BANK_SIZE = GROUPS * PER_GROUP;

  // The one input selector value that the block does not use.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // A function code that the slave does not serve.
  localparam logic [7:0] FC_UNKNOWN = 8'd7;
  // Kinds of result word.
  localparam logic KIND_BUS   = 1'b0;
  localparam logic KIND_LOCAL = 1'b1;

  // Cycles allowed for the block to settle once nothing is expected.
  localparam int SETTLE_CYCLES = 200;
  // Length of the long receiver hold-off.
  localparam int HOLD_CYCLES   = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // rx_byte[7:0], group[15:8], address[23:16], value[39:24]
  logic [1:0]  s_axis_tuser;   // command[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;   // tx_byte[7:0], read_value[23:8]
  logic        m_axis_tuser;   // kind[0]
  logic        m_axis_tlast;

  modbus_rtu_slave_register_bank #(
    .GROUPS   (GROUPS),
    .PER_GROUP(PER_GROUP),
    .RESP_MAX (RESP_MAX)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // One expected result word.
  typedef struct {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [15:0] read_value;
  } result_word_t;

  result_word_t expected_words[$];

  // Slave model state.
  logic [7:0]  own_id;
  logic [2:0]  rx_pos;
  logic [7:0]  frame_buf [8];
  logic [15:0] bank_copy [BANK_SIZE];
  logic [7:0]  reply_buf [RESP_MAX];

  int  errors = 0;
  int  words_sent = 0;
  bit  no_idle = 1'b0;        // when set, neither side idles
  int  hold_requests = 0;     // bumped by a test to ask for a long hold-off

  // --------------------------------------------------------------------------
  // Model of the slave.
  // --------------------------------------------------------------------------
  function automatic logic [15:0] model_crc16(input int n, input bit from_reply);
    logic [15:0] c;
    logic [7:0]  b;
    c = 16'hFFFF;
    for (int k = 0; k < n; k++) begin
      b = from_reply ? reply_buf[k] : frame_buf[k];
      c ^= {8'h00, b};
      for (int s = 0; s < 8; s++) begin
        c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] bank_word(input int unsigned g, input int unsigned a);
    if (g >= GROUPS || a >= PER_GROUP) return 16'h0000;
    return bank_copy[g * PER_GROUP + a];
  endfunction

  function automatic void bank_store(input int unsigned g, input int unsigned a,
                                     input logic [15:0] v);
    if (g < GROUPS && a < PER_GROUP) bank_copy[g * PER_GROUP + a] = v;
  endfunction

  // Appends the CRC to the first plen reply bytes and queues the whole reply.
  function automatic void queue_reply(input int plen);
    logic [15:0]  c;
    result_word_t w;
    c = model_crc16(plen, 1'b1);
    reply_buf[plen]     = c[7:0];
    reply_buf[plen + 1] = c[15:8];
    for (int k = 0; k < plen + 2; k++) begin
      w.kind       = KIND_BUS;
      w.tx_byte    = reply_buf[k];
      w.last       = (k == plen + 1);
      w.read_value = 16'h0000;
      expected_words.push_back(w);
    end
  endfunction

  // Serves a complete frame whose CRC has been found good.
  function automatic void serve_request();
    logic [7:0]  fc;
    logic [15:0] start, amount, idx, v;
    int unsigned cnt, bc, plen, g;
    fc     = frame_buf[1];
    start  = {frame_buf[2], frame_buf[3]};
    amount = {frame_buf[4], frame_buf[5]};
    if (fc == FC_READ_COILS || fc == FC_READ_DISCRETE) begin
      g   = fc - 1;
      cnt = amount;
      if (cnt == 0) return;
      bc   = (cnt - 1) / 8 + 1;
      plen = 3 + bc;
      if (plen + 2 > RESP_MAX) return;
      reply_buf[0] = frame_buf[0];
      reply_buf[1] = fc;
      reply_buf[2] = bc[7:0];
      for (int k = 0; k < bc; k++) reply_buf[3 + k] = 8'h00;
      for (int unsigned k = 0; k < cnt; k++) begin
        idx = start + k[15:0];
        v   = bank_word(g, idx);
        reply_buf[3 + k / 8][k % 8] = v[0];
      end
      queue_reply(plen);
    end else if (fc == FC_READ_HOLDING || fc == FC_READ_INPUT) begin
      g = fc - 1;
      // The five extra words of an input read wrap in 16 bits.
      idx = (fc == FC_READ_INPUT) ? amount + INPUT_EXTRA : amount;
      cnt = idx;
      if (cnt == 0) return;
      bc   = cnt * 2;
      plen = 3 + bc;
      if (plen + 2 > RESP_MAX) return;
      reply_buf[0] = frame_buf[0];
      reply_buf[1] = fc;
      reply_buf[2] = bc[7:0];
      for (int unsigned k = 0; k < cnt; k++) begin
        idx = start + k[15:0];
        v   = bank_word(g, idx);
        reply_buf[3 + 2 * k] = v[15:8];
        reply_buf[4 + 2 * k] = v[7:0];
      end
      queue_reply(plen);
    end else if (fc == FC_WRITE_COIL || fc == FC_WRITE_REG) begin
      if (fc == FC_WRITE_COIL) bank_store(0, start, (amount == COIL_ON) ? 16'd1 : 16'd0);
      else bank_store(2, start, amount);
      for (int k = 0; k < 6; k++) reply_buf[k] = frame_buf[k];
      queue_reply(6);
    end
  endfunction

  // Works out what one accepted input word causes.
  function automatic void predict_slave(input logic [1:0] cmd, input logic [7:0] b,
                                        input logic [7:0] g, input logic [7:0] a,
                                        input logic [15:0] v);
    result_word_t w;
    logic [15:0]  c;
    if (cmd == CMD_WRITE) begin
      bank_store(g, a, v);
    end else if (cmd == CMD_READ) begin
      w.kind       = KIND_LOCAL;
      w.tx_byte    = 8'h00;
      w.last       = 1'b1;
      w.read_value = bank_word(g, a);
      expected_words.push_back(w);
    end else if (cmd == CMD_BUS) begin
      if (rx_pos == 3'd0) begin
        if (b == own_id) begin
          frame_buf[0] = b;
          rx_pos = 3'd1;
        end
      end else begin
        frame_buf[rx_pos] = b;
        if (rx_pos != FRAME_LAST) begin
          rx_pos++;
        end else begin
          rx_pos = 3'd0;
          c = model_crc16(6, 1'b0);
          if (frame_buf[6] == c[7:0] && frame_buf[7] == c[15:8]) serve_request();
        end
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender side.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [1:0] cmd, input logic [7:0] b,
                           input logic [7:0] g, input logic [7:0] a,
                           input logic [15:0] v);
    while (!no_idle && $urandom_range(0, 99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {v, a, g, b};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_slave(cmd, b, g, a, v);
    words_sent++;
  endtask

  task automatic send_bus_byte(input logic [7:0] b);
    send_word(CMD_BUS, b, 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // Sends one request frame. A corrupt frame gets a wrong CRC high byte; with
  // mix_local a random local access lands in the middle of the frame.
  task automatic send_frame(input logic [7:0] id, input logic [7:0] fc,
                            input logic [15:0] start, input logic [15:0] amount,
                            input bit corrupt, input bit mix_local);
    logic [7:0]  f [8];
    logic [15:0] c;
    f[0] = id; f[1] = fc;
    f[2] = start[15:8]; f[3] = start[7:0];
    f[4] = amount[15:8]; f[5] = amount[7:0];
    c = 16'hFFFF;
    for (int k = 0; k < 6; k++) begin
      c ^= {8'h00, f[k]};
      for (int s = 0; s < 8; s++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    f[6] = c[7:0];
    f[7] = corrupt ? ~c[15:8] : c[15:8];
    for (int k = 0; k < 8; k++) begin
      send_bus_byte(f[k]);
      if (mix_local && k == 3) begin
        send_word($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, 8'($urandom),
                  8'($urandom_range(0, GROUPS - 1)), 8'($urandom_range(0, PER_GROUP - 1)),
                  16'($urandom));
      end
    end
  endtask

  task automatic write_own_id(input logic [7:0] id);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= id;
    do @(posedge clk_i); while (!cfg_ready_o);
    own_id = id;
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every expected word has come and the block has gone quiet.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: checks each accepted word and paces tready.
  // --------------------------------------------------------------------------
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk_i) begin
    result_word_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word tdata=%h tuser=%b tlast=%b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (m_axis_tuser !== w.kind) begin
          $error("kind: expected %0d, got %0d", w.kind, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[7:0] !== w.tx_byte) begin
          $error("tx_byte: expected %h, got %h", w.tx_byte, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tlast !== w.last) begin
          $error("last: expected %0d, got %0d", w.last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tdata[23:8] !== w.read_value) begin
          $error("read_value: expected %h, got %h", w.read_value, m_axis_tdata[23:8]);
          errors++;
        end
      end
    end
    // A new request for a hold-off starts a long stretch with tready low.
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 27);
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Local accesses at the extremes of group, address and value.
  task automatic test_local_access();
    send_word(CMD_WRITE, 8'h00, 8'd0, 8'd0, 16'hFFFF);
    send_word(CMD_WRITE, 8'hFF, 8'd3, 8'd31, 16'hA5C3);
    send_word(CMD_WRITE, 8'h00, 8'd255, 8'd0, 16'h1234);   // group out of range
    send_word(CMD_WRITE, 8'h00, 8'd1, 8'd255, 16'h5678);   // address out of range
    send_word(CMD_READ, 8'h00, 8'd0, 8'd0, 16'h0000);
    send_word(CMD_READ, 8'h00, 8'd3, 8'd31, 16'hFFFF);
    send_word(CMD_READ, 8'h00, 8'd255, 8'd255, 16'h0000);
    send_word(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);  // ignored selector
  endtask

  // Every function code and the special cases of frame service.
  task automatic test_functions();
    send_frame(own_id, FC_WRITE_COIL, 16'd1, COIL_ON, 1'b0, 1'b0);
    send_frame(own_id, FC_WRITE_COIL, 16'd2, 16'hFF01, 1'b0, 1'b0); // stores zero
    send_frame(own_id, FC_READ_COILS, 16'd0, 16'd8, 1'b0, 1'b0);
    send_frame(own_id, FC_READ_DISCRETE, 16'hFFFE, 16'd5, 1'b0, 1'b0); // wraps around
    send_frame(own_id, FC_WRITE_REG, 16'd31, 16'hBEEF, 1'b0, 1'b1);
    send_frame(own_id, FC_WRITE_REG, 16'd40, 16'h1111, 1'b0, 1'b0); // outside, echoed
    send_frame(own_id, FC_READ_HOLDING, 16'd29, 16'd4, 1'b0, 1'b0);
    send_frame(own_id, FC_READ_HOLDING, 16'd0, 16'd29, 1'b0, 1'b0); // longest word read
    send_frame(own_id, FC_READ_HOLDING, 16'd0, 16'd30, 1'b0, 1'b0); // too long
    send_frame(own_id, FC_READ_INPUT, 16'd0, 16'd2, 1'b0, 1'b0);
    send_frame(own_id, FC_READ_INPUT, 16'd0, 16'hFFFB, 1'b0, 1'b0); // count wraps to zero
    send_frame(own_id, FC_READ_COILS, 16'd0, 16'd0, 1'b0, 1'b0);    // zero count
    send_frame(own_id, FC_READ_COILS, 16'd0, 16'd472, 1'b0, 1'b0);  // longest bit read
    send_frame(own_id, FC_READ_COILS, 16'd0, 16'hFFFF, 1'b0, 1'b0); // far too long
    send_frame(own_id, FC_UNKNOWN, 16'd0, 16'd1, 1'b0, 1'b0);
    send_frame(own_id, FC_READ_HOLDING, 16'd0, 16'd1, 1'b1, 1'b0);  // bad CRC
    send_frame(own_id + 8'd1, FC_READ_HOLDING, 16'd0, 16'd1, 1'b0, 1'b0); // not ours
    wait_drained();
  endtask

  // Random frames with random content, broken frames and noise.
  task automatic test_random_traffic(input int goal);
    logic [7:0]  fc;
    logic [15:0] start, amount;
    int          pick;
    while (words_sent < goal) begin
      // One stretch runs with no idling on either side.
      no_idle = (words_sent > goal - 55 && words_sent < goal - 10);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        fc    = 8'($urandom_range(1, 6));
        start = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        case (fc)
          FC_READ_COILS, FC_READ_DISCRETE: amount = 16'($urandom_range(0, 60));
          FC_READ_HOLDING: amount = 16'($urandom_range(0, 30));
          FC_READ_INPUT: begin
            amount = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(16'hFFFA, 16'hFFFF))
                                                 : 16'($urandom_range(0, 25));
          end
          FC_WRITE_COIL: amount = $urandom_range(0, 1) ? COIL_ON : 16'($urandom);
          default: amount = 16'($urandom);
        endcase
        if ($urandom_range(0, 19) == 0) fc = 8'($urandom);
        send_frame(own_id, fc, start, amount, $urandom_range(0, 14) == 0,
                   $urandom_range(0, 9) == 0);
      end else if (pick < 80) begin
        send_bus_byte(8'($urandom));
      end else begin
        send_word(2'($urandom_range(1, 3)), 8'($urandom),
                  ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)),
                  ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31)),
                  16'($urandom));
      end
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  // Frames on other slave ids, the extremes included.
  task automatic test_slave_ids();
    logic [7:0] ids [3];
    ids = '{8'd0, 8'd255, 8'($urandom)};
    foreach (ids[i]) begin
      write_own_id(ids[i]);
      send_frame(ids[i], FC_READ_HOLDING, 16'd0, 16'd2, 1'b0, 1'b0);
      send_frame(ids[i] ^ 8'h80, FC_READ_HOLDING, 16'd0, 16'd2, 1'b0, 1'b0);
      send_frame(ids[i], FC_WRITE_REG, 16'($urandom_range(0, 31)), 16'($urandom),
                 1'b0, 1'b0);
      wait_drained();
    end
  endtask

  // The receiver holds off while long replies pile up behind it.
  task automatic test_backpressure();
    hold_requests++;
    repeat (4) send_frame(own_id, FC_READ_HOLDING, 16'd0, 16'd12, 1'b0, 1'b0);
    send_word(CMD_READ, 8'h00, 8'd2, 8'd0, 16'h0000);
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 8'h00;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_BUS;
    own_id = 8'd1;
    rx_pos = 3'd0;
    foreach (frame_buf[i]) frame_buf[i] = 8'h00;
    foreach (bank_copy[i]) bank_copy[i] = 16'h0000;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_local_access();
    test_functions();
    test_slave_ids();
    test_backpressure();
    test_random_traffic(words_sent + 60);

    if (errors == 0 && expected_words.size() == 0) begin
      $display("PASS modbus_rtu_slave_register_bank");
    end else begin
      if (expected_words.size() != 0) begin
        $error("%0d expected result words never arrived", expected_words.size());
      end
      $display("FAIL modbus_rtu_slave_register_bank");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAIL modbus_rtu_slave_register_bank");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/mbrs_pkg.sv
hw/rtl/mbrs_ram.sv
hw/rtl/mbrs_datapath.sv
hw/rtl/mbrs_ctrl.sv
hw/rtl/modbus_rtu_slave_register_bank.sv
bench/modbus_rtu_slave_register_bank_tb.sv
